@@ hdl/ifpm_pkg.sv @@
package ifpm_pkg;

  localparam int QW     = 32;
  localparam int SW     = 31;
  localparam int NUMW   = 96;
  localparam int NLANE  = 6;
  localparam int STEPS  = 32;
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] MODE_FILL    = 2'd0;
  localparam logic [1:0] MODE_FIT     = 2'd1;
  localparam logic [1:0] MODE_STRETCH = 2'd2;
  localparam logic [1:0] MODE_TILE    = 2'd3;

  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_PASS     = 2'd1;
  localparam logic [1:0] ST_SINGULAR = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  localparam logic [1:0] CFG_SCALE_FACTOR = 2'd0;
  localparam logic [1:0] CFG_ORIG_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_ORIG_HEIGHT  = 2'd2;

  localparam logic [SW-1:0] SCALE_RESET = 31'd32768;

  localparam int L_A  = 0;
  localparam int L_B  = 1;
  localparam int L_C  = 2;
  localparam int L_D  = 3;
  localparam int L_TX = 4;
  localparam int L_TY = 5;

  typedef struct packed {
    logic [1:0]           scale_mode;
    logic signed [QW-1:0] image_width;
    logic signed [QW-1:0] image_height;
    logic signed [QW-1:0] node_width;
    logic signed [QW-1:0] node_height;
    logic signed [QW-1:0] paint_a;
    logic signed [QW-1:0] paint_b;
    logic signed [QW-1:0] paint_c;
    logic signed [QW-1:0] paint_d;
    logic signed [QW-1:0] paint_tx;
    logic signed [QW-1:0] paint_ty;
  } ifpm_in_t;

  typedef struct packed {
    logic signed [QW-1:0] out_a;
    logic signed [QW-1:0] out_b;
    logic signed [QW-1:0] out_c;
    logic signed [QW-1:0] out_d;
    logic signed [QW-1:0] out_tx;
    logic signed [QW-1:0] out_ty;
    logic [1:0]           status;
  } ifpm_out_t;

  typedef struct packed {
    logic [NLANE-1:0]           lane_en;
    logic [NLANE-1:0]           lane_neg;
    logic [NLANE-1:0][NUMW-1:0] num;
    logic [NLANE-1:0][NUMW-1:0] den;
    logic [NLANE-1:0][QW-1:0]   fixed;
    logic                       margin;
    logic                       pass;
    logic                       singular;
    logic [SW-1:0]              nw;
    logic [SW-1:0]              iw;
    logic [SW-1:0]              nh;
    logic [SW-1:0]              ih;
  } ifpm_job_t;

endpackage

@@ hdl/ifpm_queue.sv @@
module ifpm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ifpm_pkg::ifpm_job_t din,
  input  logic                pop,
  output ifpm_pkg::ifpm_job_t dout,
  output logic                full,
  output logic                empty
);

  ifpm_pkg::ifpm_job_t         mem_r [ifpm_pkg::QDEPTH];
  logic [ifpm_pkg::QAW-1:0]    wp_r;
  logic [ifpm_pkg::QAW-1:0]    rp_r;
  logic [ifpm_pkg::QAW:0]      cnt_r;

  assign full  = (cnt_r == (ifpm_pkg::QAW + 1)'(ifpm_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hdl/ifpm_front.sv @@
module ifpm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  ifpm_pkg::ifpm_in_t  in_data,
  input  logic [30:0]         scale_factor,
  input  logic [30:0]         orig_width,
  input  logic [30:0]         orig_height,
  input  logic                q_full,
  output logic                q_push,
  output ifpm_pkg::ifpm_job_t q_job,
  output logic                stall
);

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    ifpm_pkg::ifpm_in_t item;
    logic               invalid;
    logic               ident;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic [31:0]        mc;
    logic [31:0]        md;
    logic signed [63:0] p_ad;
    logic signed [63:0] p_bc;
    logic signed [63:0] p_cty;
    logic signed [63:0] p_dtx;
    logic signed [63:0] p_btx;
    logic signed [63:0] p_aty;
    logic [62:0]        m_dnw;
    logic [62:0]        m_bnh;
    logic [62:0]        m_cnw;
    logic [62:0]        m_anh;
    logic [61:0]        x_iwnh;
    logic [61:0]        x_nwih;
    logic [61:0]        x_nwnh;
    logic [61:0]        t_w;
    logic [61:0]        t_h;
    logic               wide;
    logic               tall;
    logic [63:0]        dmag;
    logic [63:0]        emag;
    logic [63:0]        fmag;
    logic               dneg;
    logic               eneg;
    logic               fneg;
    logic [62:0]        pp_w_lo;
    logic [62:0]        pp_w_hi;
    logic [62:0]        pp_h_lo;
    logic [62:0]        pp_h_hi;
    logic [62:0]        pp_e_lo;
    logic [62:0]        pp_e_hi;
    logic [62:0]        pp_f_lo;
    logic [62:0]        pp_f_hi;
    logic [95:0]        den_w;
    logic [95:0]        den_h;
    logic [95:0]        en;
    logic [95:0]        fn;
    logic [62:0]        px0;
    logic [62:0]        px1;
    logic [62:0]        px2;
    logic [125:0]       xprod;
    logic [101:0]       lhs;
    logic               big;
  } fr_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic not_pos(input logic [31:0] x);
    return x[31] || (x == 32'd0);
  endfunction

  logic [8:1] v_r;
  logic       adv;
  fr_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r;
  fr_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt;

  assign adv    = !v_r[8] || !q_full;
  assign stall  = !adv;
  assign q_push = v_r[8] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[7:1], take};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
      s8_r <= s8_nxt;
    end
  end

  always_comb begin
    s1_nxt         = '0;
    s1_nxt.item    = in_data;
    s1_nxt.invalid = not_pos(in_data.image_width) || not_pos(in_data.image_height) ||
                     not_pos(in_data.node_width) || not_pos(in_data.node_height);
    s1_nxt.ident   = (in_data.paint_a == ONE_Q16) && (in_data.paint_b == '0) &&
                     (in_data.paint_c == '0) && (in_data.paint_d == ONE_Q16) &&
                     (in_data.paint_tx == '0) && (in_data.paint_ty == '0);
    s1_nxt.ma      = mag32(in_data.paint_a);
    s1_nxt.mb      = mag32(in_data.paint_b);
    s1_nxt.mc      = mag32(in_data.paint_c);
    s1_nxt.md      = mag32(in_data.paint_d);
  end

  always_comb begin
    s2_nxt        = s1_r;
    s2_nxt.p_ad   = 64'($signed(s1_r.item.paint_a)) * 64'($signed(s1_r.item.paint_d));
    s2_nxt.p_bc   = 64'($signed(s1_r.item.paint_b)) * 64'($signed(s1_r.item.paint_c));
    s2_nxt.p_cty  = 64'($signed(s1_r.item.paint_c)) * 64'($signed(s1_r.item.paint_ty));
    s2_nxt.p_dtx  = 64'($signed(s1_r.item.paint_d)) * 64'($signed(s1_r.item.paint_tx));
    s2_nxt.p_btx  = 64'($signed(s1_r.item.paint_b)) * 64'($signed(s1_r.item.paint_tx));
    s2_nxt.p_aty  = 64'($signed(s1_r.item.paint_a)) * 64'($signed(s1_r.item.paint_ty));
    s2_nxt.m_dnw  = 63'(s1_r.md) * 63'(s1_r.item.node_width[30:0]);
    s2_nxt.m_bnh  = 63'(s1_r.mb) * 63'(s1_r.item.node_height[30:0]);
    s2_nxt.m_cnw  = 63'(s1_r.mc) * 63'(s1_r.item.node_width[30:0]);
    s2_nxt.m_anh  = 63'(s1_r.ma) * 63'(s1_r.item.node_height[30:0]);
    s2_nxt.x_iwnh = 62'(s1_r.item.image_width[30:0]) * 62'(s1_r.item.node_height[30:0]);
    s2_nxt.x_nwih = 62'(s1_r.item.node_width[30:0]) * 62'(s1_r.item.image_height[30:0]);
    s2_nxt.x_nwnh = 62'(s1_r.item.node_width[30:0]) * 62'(s1_r.item.node_height[30:0]);
    s2_nxt.t_w    = 62'(scale_factor) * 62'(orig_width);
    s2_nxt.t_h    = 62'(scale_factor) * 62'(orig_height);
  end

  always_comb begin
    logic [63:0] dd, ee, ff;
    dd          = s2_r.p_ad - s2_r.p_bc;
    ee          = s2_r.p_cty - s2_r.p_dtx;
    ff          = s2_r.p_btx - s2_r.p_aty;
    s3_nxt      = s2_r;
    s3_nxt.dneg = dd[63];
    s3_nxt.eneg = ee[63];
    s3_nxt.fneg = ff[63];
    s3_nxt.dmag = mag64(dd);
    s3_nxt.emag = mag64(ee);
    s3_nxt.fmag = mag64(ff);
    s3_nxt.wide = s2_r.x_iwnh > s2_r.x_nwih;
    s3_nxt.tall = s2_r.x_nwih > s2_r.x_iwnh;
  end

  always_comb begin
    s4_nxt         = s3_r;
    s4_nxt.pp_w_lo = 63'(s3_r.dmag[31:0]) * 63'(s3_r.item.image_width[30:0]);
    s4_nxt.pp_w_hi = 63'(s3_r.dmag[63:32]) * 63'(s3_r.item.image_width[30:0]);
    s4_nxt.pp_h_lo = 63'(s3_r.dmag[31:0]) * 63'(s3_r.item.image_height[30:0]);
    s4_nxt.pp_h_hi = 63'(s3_r.dmag[63:32]) * 63'(s3_r.item.image_height[30:0]);
    s4_nxt.pp_e_lo = 63'(s3_r.emag[31:0]) * 63'(s3_r.item.node_width[30:0]);
    s4_nxt.pp_e_hi = 63'(s3_r.emag[63:32]) * 63'(s3_r.item.node_width[30:0]);
    s4_nxt.pp_f_lo = 63'(s3_r.fmag[31:0]) * 63'(s3_r.item.node_height[30:0]);
    s4_nxt.pp_f_hi = 63'(s3_r.fmag[63:32]) * 63'(s3_r.item.node_height[30:0]);
  end

  always_comb begin
    s5_nxt       = s4_r;
    s5_nxt.den_w = 96'({s4_r.pp_w_hi, 32'd0}) + 96'(s4_r.pp_w_lo);
    s5_nxt.den_h = 96'({s4_r.pp_h_hi, 32'd0}) + 96'(s4_r.pp_h_lo);
    s5_nxt.en    = 96'({s4_r.pp_e_hi, 32'd0}) + 96'(s4_r.pp_e_lo);
    s5_nxt.fn    = 96'({s4_r.pp_f_hi, 32'd0}) + 96'(s4_r.pp_f_lo);
  end

  always_comb begin
    s6_nxt     = s5_r;
    s6_nxt.px0 = 63'(s5_r.den_w[31:0]) * 63'(s5_r.item.image_height[30:0]);
    s6_nxt.px1 = 63'(s5_r.den_w[63:32]) * 63'(s5_r.item.image_height[30:0]);
    s6_nxt.px2 = 63'(s5_r.den_w[95:64]) * 63'(s5_r.item.image_height[30:0]);
  end

  always_comb begin
    s7_nxt       = s6_r;
    s7_nxt.xprod = 126'({s6_r.px2, 64'd0}) + 126'({s6_r.px1, 32'd0}) + 126'(s6_r.px0);
  end

  always_comb begin
    s8_nxt     = s7_r;
    s8_nxt.big = |s7_r.xprod[125:88];
    s8_nxt.lhs = 102'(s7_r.xprod[87:0]) * 102'(15625);
  end

  always_comb begin
    logic          singular;
    logic          use_h;
    logic [30:0]   nw, iw, nh, ih, n_sel, i_sel;
    nw       = s8_r.item.node_width[30:0];
    iw       = s8_r.item.image_width[30:0];
    nh       = s8_r.item.node_height[30:0];
    ih       = s8_r.item.image_height[30:0];
    singular = !s8_r.big && (s8_r.lhs <= 102'({s8_r.x_nwnh, 26'd0}));
    use_h    = (s8_r.item.scale_mode == ifpm_pkg::MODE_FILL) ? s8_r.wide : s8_r.tall;
    n_sel    = use_h ? nh : nw;
    i_sel    = use_h ? ih : iw;
    q_job    = '0;
    q_job.nw = nw;
    q_job.iw = iw;
    q_job.nh = nh;
    q_job.ih = ih;
    if (s8_r.invalid) begin
      q_job.pass                    = 1'b1;
      q_job.fixed[ifpm_pkg::L_A]  = s8_r.item.paint_a;
      q_job.fixed[ifpm_pkg::L_B]  = s8_r.item.paint_b;
      q_job.fixed[ifpm_pkg::L_C]  = s8_r.item.paint_c;
      q_job.fixed[ifpm_pkg::L_D]  = s8_r.item.paint_d;
      q_job.fixed[ifpm_pkg::L_TX] = s8_r.item.paint_tx;
      q_job.fixed[ifpm_pkg::L_TY] = s8_r.item.paint_ty;
    end else begin
      case (s8_r.item.scale_mode)
        ifpm_pkg::MODE_FILL, ifpm_pkg::MODE_FIT: begin
          q_job.margin                  = 1'b1;
          q_job.lane_en[ifpm_pkg::L_A] = 1'b1;
          q_job.lane_en[ifpm_pkg::L_D] = 1'b1;
          q_job.num[ifpm_pkg::L_A]     = 96'({n_sel, 16'd0});
          q_job.num[ifpm_pkg::L_D]     = 96'({n_sel, 16'd0});
          q_job.den[ifpm_pkg::L_A]     = 96'(i_sel);
          q_job.den[ifpm_pkg::L_D]     = 96'(i_sel);
        end
        ifpm_pkg::MODE_STRETCH: begin
          if (s8_r.ident || singular) begin
            q_job.singular                = !s8_r.ident;
            q_job.lane_en[ifpm_pkg::L_A] = 1'b1;
            q_job.lane_en[ifpm_pkg::L_D] = 1'b1;
            q_job.num[ifpm_pkg::L_A]     = 96'({nw, 16'd0});
            q_job.num[ifpm_pkg::L_D]     = 96'({nh, 16'd0});
            q_job.den[ifpm_pkg::L_A]     = 96'(iw);
            q_job.den[ifpm_pkg::L_D]     = 96'(ih);
          end else begin
            q_job.lane_en                  = '1;
            q_job.num[ifpm_pkg::L_A]      = 96'({s8_r.m_dnw, 32'd0});
            q_job.num[ifpm_pkg::L_B]      = 96'({s8_r.m_bnh, 32'd0});
            q_job.num[ifpm_pkg::L_C]      = 96'({s8_r.m_cnw, 32'd0});
            q_job.num[ifpm_pkg::L_D]      = 96'({s8_r.m_anh, 32'd0});
            q_job.num[ifpm_pkg::L_TX]     = s8_r.en;
            q_job.num[ifpm_pkg::L_TY]     = s8_r.fn;
            q_job.den[ifpm_pkg::L_A]      = s8_r.den_w;
            q_job.den[ifpm_pkg::L_B]      = s8_r.den_w;
            q_job.den[ifpm_pkg::L_C]      = s8_r.den_h;
            q_job.den[ifpm_pkg::L_D]      = s8_r.den_h;
            q_job.den[ifpm_pkg::L_TX]     = 96'(s8_r.dmag);
            q_job.den[ifpm_pkg::L_TY]     = 96'(s8_r.dmag);
            q_job.lane_neg[ifpm_pkg::L_A] = s8_r.item.paint_d[31] ^ s8_r.dneg;
            q_job.lane_neg[ifpm_pkg::L_B] = !(s8_r.item.paint_b[31] ^ s8_r.dneg);
            q_job.lane_neg[ifpm_pkg::L_C] = !(s8_r.item.paint_c[31] ^ s8_r.dneg);
            q_job.lane_neg[ifpm_pkg::L_D] = s8_r.item.paint_a[31] ^ s8_r.dneg;
            q_job.lane_neg[ifpm_pkg::L_TX] = s8_r.eneg ^ s8_r.dneg;
            q_job.lane_neg[ifpm_pkg::L_TY] = s8_r.fneg ^ s8_r.dneg;
          end
        end
        default: begin
          q_job.fixed[ifpm_pkg::L_A]   = {1'b0, scale_factor};
          q_job.fixed[ifpm_pkg::L_D]   = {1'b0, scale_factor};
          q_job.lane_en[ifpm_pkg::L_A] = (orig_width != '0);
          q_job.lane_en[ifpm_pkg::L_D] = (orig_height != '0);
          q_job.num[ifpm_pkg::L_A]     = 96'(s8_r.t_w);
          q_job.num[ifpm_pkg::L_D]     = 96'(s8_r.t_h);
          q_job.den[ifpm_pkg::L_A]     = 96'(iw);
          q_job.den[ifpm_pkg::L_D]     = 96'(ih);
        end
      endcase
    end
  end

endmodule

@@ hdl/ifpm_div.sv @@
module ifpm_div (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [95:0] num,
  input  logic [95:0] den,
  input  logic        neg,
  output logic [31:0] res,
  output logic        sat
);

  logic [95:0] den_r;
  logic [95:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] q_r;
  logic        neg_r;
  logic        ovf_r;
  logic [96:0] rem2;
  logic [96:0] dext;
  logic [96:0] diff;
  logic        ge;
  logic        rnd;
  logic [32:0] qf;
  logic [32:0] lim;

  assign dext = {1'b0, den_r};
  assign rem2 = {rem_r, lo_r[31]};
  assign diff = rem2 - dext;
  assign ge   = (rem2 >= dext);
  assign rnd  = ({rem_r, 1'b0} >= dext);
  assign qf   = {1'b0, q_r} + 33'(rnd);
  assign lim  = neg_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign sat  = ovf_r || (qf > lim);

  always_comb begin
    if (sat) begin
      res = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = neg_r ? (32'd0 - qf[31:0]) : qf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      den_r <= den;
      rem_r <= {32'd0, num[95:32]};
      lo_r  <= num[31:0];
      q_r   <= '0;
      neg_r <= neg;
      ovf_r <= ({32'd0, num[95:32]} >= den);
    end else if (step) begin
      rem_r <= ge ? diff[95:0] : rem2[95:0];
      lo_r  <= {lo_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], ge};
    end
  end

endmodule

@@ hdl/ifpm_back.sv @@
module ifpm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ifpm_pkg::ifpm_job_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  output ifpm_pkg::ifpm_out_t out_data
);

  localparam int CW = $clog2(ifpm_pkg::STEPS);

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_RES, B_MUL, B_FIN} bstate_t;

  function automatic logic [32:0] margin_q(input logic [30:0] n, input logic [61:0] p);
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] r;
    logic        neg;
    logic        ovf;
    logic [31:0] q;
    v   = {17'd0, n, 16'd0} - {2'b00, p};
    neg = v[63];
    mag = neg ? (64'd0 - v) : v;
    r   = (mag + 64'h1_0000) >> 17;
    ovf = neg ? (r > 64'h8000_0000) : (r > 64'h7FFF_FFFF);
    if (ovf) begin
      q = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      q = neg ? (32'd0 - r[31:0]) : r[31:0];
    end
    return {ovf, q};
  endfunction

  bstate_t                                  state_r;
  logic [CW-1:0]                            cnt_r;
  ifpm_pkg::ifpm_job_t                      job_r;
  logic [ifpm_pkg::NLANE-1:0][31:0]         res_r;
  logic                                     sat_r;
  logic [61:0]                              prod_w_r;
  logic [61:0]                              prod_h_r;
  logic                                     out_valid_r;
  ifpm_pkg::ifpm_out_t                      out_data_r;
  logic [ifpm_pkg::NLANE-1:0][31:0]         lres;
  logic [ifpm_pkg::NLANE-1:0]               lsat;
  logic                                     load;
  logic                                     step;
  logic [32:0]                              mw;
  logic [32:0]                              mh;
  logic                                     fin_sat;

  assign load      = (state_r == B_IDLE) && !q_empty;
  assign step      = (state_r == B_DIV);
  assign q_pop     = load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar k = 0; k < ifpm_pkg::NLANE; k++) begin : g_lane
    ifpm_div u_div (
      .clk  (clk),
      .load (load),
      .step (step),
      .num  (q_data.num[k]),
      .den  (q_data.den[k]),
      .neg  (q_data.lane_neg[k]),
      .res  (lres[k]),
      .sat  (lsat[k])
    );
  end

  assign mw      = margin_q(job_r.nw, prod_w_r);
  assign mh      = margin_q(job_r.nh, prod_h_r);
  assign fin_sat = sat_r || (job_r.margin && (mw[32] || mh[32]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_data;
            cnt_r   <= '0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(ifpm_pkg::STEPS - 1)) begin
            state_r <= B_RES;
          end
        end
        B_RES: begin
          for (int k = 0; k < ifpm_pkg::NLANE; k++) begin
            res_r[k] <= job_r.lane_en[k] ? lres[k] : job_r.fixed[k];
          end
          sat_r   <= |(lsat & job_r.lane_en);
          state_r <= B_MUL;
        end
        B_MUL: begin
          prod_w_r <= 62'(job_r.iw) * 62'(res_r[ifpm_pkg::L_A][30:0]);
          prod_h_r <= 62'(job_r.ih) * 62'(res_r[ifpm_pkg::L_A][30:0]);
          state_r  <= B_FIN;
        end
        B_FIN: begin
          out_data_r.out_a  <= res_r[ifpm_pkg::L_A];
          out_data_r.out_b  <= res_r[ifpm_pkg::L_B];
          out_data_r.out_c  <= res_r[ifpm_pkg::L_C];
          out_data_r.out_d  <= res_r[ifpm_pkg::L_D];
          out_data_r.out_tx <= job_r.margin ? mw[31:0] : res_r[ifpm_pkg::L_TX];
          out_data_r.out_ty <= job_r.margin ? mh[31:0] : res_r[ifpm_pkg::L_TY];
          if (job_r.pass) begin
            out_data_r.status <= ifpm_pkg::ST_PASS;
          end else if (fin_sat) begin
            out_data_r.status <= ifpm_pkg::ST_SAT;
          end else if (job_r.singular) begin
            out_data_r.status <= ifpm_pkg::ST_SINGULAR;
          end else begin
            out_data_r.status <= ifpm_pkg::ST_NORMAL;
          end
          out_valid_r <= 1'b1;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/image_fit_pattern_matrix.sv @@
// Pattern matrix unit. An item is taken on a clock edge with start high and busy low; its
// result appears on out_data for exactly one cycle with out_valid high, and the receiver
// cannot stall it. An item first passes an eight-stage classify and multiply pipeline that
// takes one item per clock while busy is low, then waits in a two-entry queue for the
// divider back end. The back end runs six 32-step restoring divider lanes in parallel and
// takes no new item until it has finished the last one, which sets the sustained rate.
// busy rises only when the last pipeline stage holds an item and the queue is full.
// Configuration writes are always ready and must be issued only while no item is in flight.
module image_fit_pattern_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ifpm_pkg::ifpm_in_t  in_data,
  output logic                out_valid,
  output ifpm_pkg::ifpm_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);

  logic [30:0]         scale_r;
  logic [30:0]         orig_w_r;
  logic [30:0]         orig_h_r;
  logic                take;
  logic                stall;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  ifpm_pkg::ifpm_job_t q_in;
  ifpm_pkg::ifpm_job_t q_out;

  assign cfg_ready = 1'b1;
  assign busy      = stall;
  assign take      = start && !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= ifpm_pkg::SCALE_RESET;
      orig_w_r <= '0;
      orig_h_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ifpm_pkg::CFG_SCALE_FACTOR: scale_r  <= cfg_data;
        ifpm_pkg::CFG_ORIG_WIDTH:   orig_w_r <= cfg_data;
        ifpm_pkg::CFG_ORIG_HEIGHT:  orig_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ifpm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_data      (in_data),
    .scale_factor (scale_r),
    .orig_width   (orig_w_r),
    .orig_height  (orig_h_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_in),
    .stall        (stall)
  );

  ifpm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  ifpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hdl/ifpm_checker.sv @@
module ifpm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam logic [4:0] MAX_INFLIGHT = 5'd11;

  logic [4:0] inflight_r;
  logic       acc;

  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      case ({acc, out_valid})
        2'b10:   inflight_r <= inflight_r + 1'b1;
        2'b01:   inflight_r <= inflight_r - 1'b1;
        default: inflight_r <= inflight_r;
      endcase
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 5'd0)
    else $error("result without an accepted transaction");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= MAX_INFLIGHT)
    else $error("more transactions in flight than storage");

endmodule

bind image_fit_pattern_matrix ifpm_checker u_ifpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ifpm_pkg::ifpm_in_t in_data;
  logic out_valid;
  ifpm_pkg::ifpm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;

  image_fit_pattern_matrix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [ifpm_pkg::SW-1:0] tile_scale;
  logic [ifpm_pkg::SW-1:0] tile_orig_w;
  logic [ifpm_pkg::SW-1:0] tile_orig_h;

  ifpm_pkg::ifpm_out_t matrix_q[$];
  int unsigned cycles;
  int errors;
  int items_sent;
  int matrices_seen;
  bit ovf;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [191:0] mag(logic signed [127:0] v);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    return {64'b0, m};
  endfunction

  // rounded quotient, ties away from zero, saturated
  function automatic logic [31:0] round_div(bit neg, logic [191:0] num, logic [191:0] den);
    logic [191:0] q;
    logic [191:0] r;
    logic [191:0] lim;
    q = num / den;
    r = num % den;
    if ((r << 1) >= den) q = q + 1;
    lim = neg ? 192'h80000000 : 192'h7fffffff;
    if (q > lim) begin
      q = lim;
      ovf = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic logic [31:0] inv_coef(bit neg_extra, logic signed [127:0] p,
                                           logic signed [127:0] n, logic signed [127:0] dd,
                                           logic signed [127:0] i);
    logic [191:0] num;
    logic [191:0] den;
    num = (mag(p) * 192'(n)) << 32;
    den = mag(dd) * 192'(i);
    return round_div(((p < 0) != (dd < 0)) != neg_extra, num, den);
  endfunction

  function automatic ifpm_pkg::ifpm_out_t calc_matrix(ifpm_pkg::ifpm_in_t x);
    ifpm_pkg::ifpm_out_t o;
    logic signed [127:0] iw, ih, nw, nh, pa, pb, pc, pd, ptx, pty;
    logic signed [127:0] dd, e, f, v, sv;
    logic [191:0] lhs, rhs;
    logic [31:0] s;
    bit use_h, ident, singular;
    iw = x.image_width;   ih = x.image_height;
    nw = x.node_width;    nh = x.node_height;
    pa = x.paint_a;       pb = x.paint_b;   pc = x.paint_c;
    pd = x.paint_d;       ptx = x.paint_tx; pty = x.paint_ty;
    o = '0;
    ovf = 1'b0;
    singular = 1'b0;
    if (iw <= 0 || ih <= 0 || nw <= 0 || nh <= 0) begin
      o.out_a = x.paint_a;   o.out_b = x.paint_b;   o.out_c = x.paint_c;
      o.out_d = x.paint_d;   o.out_tx = x.paint_tx; o.out_ty = x.paint_ty;
      o.status = ifpm_pkg::ST_PASS;
      return o;
    end
    case (x.scale_mode)
      ifpm_pkg::MODE_FILL, ifpm_pkg::MODE_FIT: begin
        use_h = (x.scale_mode == ifpm_pkg::MODE_FILL) ? (iw * nh > nw * ih)
                                                       : (nw * ih > iw * nh);
        s = use_h ? round_div(1'b0, 192'(nh) << 16, 192'(ih))
                  : round_div(1'b0, 192'(nw) << 16, 192'(iw));
        sv = {96'b0, s};
        o.out_a = s;
        o.out_d = s;
        v = nw * 65536 - iw * sv;
        o.out_tx = round_div(v < 0, mag(v), 192'd131072);
        v = nh * 65536 - ih * sv;
        o.out_ty = round_div(v < 0, mag(v), 192'd131072);
      end
      ifpm_pkg::MODE_STRETCH: begin
        ident = pa == 65536 && pb == 0 && pc == 0 && pd == 65536 && ptx == 0 && pty == 0;
        dd = pa * pd - pb * pc;
        if (!ident) begin
          lhs = mag(dd) * 192'(iw) * 192'(ih) * 192'd15625;
          rhs = (192'(nw) * 192'(nh)) << 26;
          singular = lhs <= rhs;
        end
        if (ident || singular) begin
          o.out_a = round_div(1'b0, 192'(nw) << 16, 192'(iw));
          o.out_d = round_div(1'b0, 192'(nh) << 16, 192'(ih));
        end else begin
          e = pc * pty - pd * ptx;
          f = pb * ptx - pa * pty;
          o.out_a = inv_coef(1'b0, pd, nw, dd, iw);
          o.out_b = inv_coef(1'b1, pb, nh, dd, iw);
          o.out_c = inv_coef(1'b1, pc, nw, dd, ih);
          o.out_d = inv_coef(1'b0, pa, nh, dd, ih);
          o.out_tx = round_div((e < 0) != (dd < 0), mag(e) * 192'(nw), mag(dd));
          o.out_ty = round_div((f < 0) != (dd < 0), mag(f) * 192'(nh), mag(dd));
        end
      end
      default: begin
        o.out_a = (tile_orig_w != 0)
          ? round_div(1'b0, 192'(tile_scale) * 192'(tile_orig_w), 192'(iw)) : {1'b0, tile_scale};
        o.out_d = (tile_orig_h != 0)
          ? round_div(1'b0, 192'(tile_scale) * 192'(tile_orig_h), 192'(ih)) : {1'b0, tile_scale};
      end
    endcase
    o.status = ovf ? ifpm_pkg::ST_SAT : (singular ? ifpm_pkg::ST_SINGULAR : ifpm_pkg::ST_NORMAL);
    return o;
  endfunction

  always @(posedge clk) begin
    ifpm_pkg::ifpm_out_t exp_m;
    if (rst_n && out_valid) begin
      matrices_seen++;
      if (matrix_q.size() == 0) begin
        $error("matrix with no transaction pending");
        errors++;
      end else begin
        exp_m = matrix_q.pop_front();
        if (out_data.out_a !== exp_m.out_a) begin
          $error("out_a exp %h got %h", exp_m.out_a, out_data.out_a); errors++;
        end
        if (out_data.out_b !== exp_m.out_b) begin
          $error("out_b exp %h got %h", exp_m.out_b, out_data.out_b); errors++;
        end
        if (out_data.out_c !== exp_m.out_c) begin
          $error("out_c exp %h got %h", exp_m.out_c, out_data.out_c); errors++;
        end
        if (out_data.out_d !== exp_m.out_d) begin
          $error("out_d exp %h got %h", exp_m.out_d, out_data.out_d); errors++;
        end
        if (out_data.out_tx !== exp_m.out_tx) begin
          $error("out_tx exp %h got %h", exp_m.out_tx, out_data.out_tx); errors++;
        end
        if (out_data.out_ty !== exp_m.out_ty) begin
          $error("out_ty exp %h got %h", exp_m.out_ty, out_data.out_ty); errors++;
        end
        if (out_data.status !== exp_m.status) begin
          $error("status exp %0d got %0d", exp_m.status, out_data.status); errors++;
        end
      end
    end
  end

  task automatic send_pattern(ifpm_pkg::ifpm_in_t x, bit allow_gap);
    int gap;
    start <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
    matrix_q.push_back(calc_matrix(x));
    items_sent++;
    gap = 0;
    if (allow_gap) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(20, 80);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ifpm_pkg::CFG_SCALE_FACTOR: tile_scale = val;
      ifpm_pkg::CFG_ORIG_WIDTH:   tile_orig_w = val;
      ifpm_pkg::CFG_ORIG_HEIGHT:  tile_orig_h = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic ifpm_pkg::ifpm_in_t mk_item(logic [1:0] m, logic [31:0] iw,
                                                 logic [31:0] ih, logic [31:0] nw,
                                                 logic [31:0] nh, logic [31:0] a,
                                                 logic [31:0] b, logic [31:0] c,
                                                 logic [31:0] d, logic [31:0] tx,
                                                 logic [31:0] ty);
    ifpm_pkg::ifpm_in_t x;
    x.scale_mode = m;
    x.image_width = iw;  x.image_height = ih;
    x.node_width = nw;   x.node_height = nh;
    x.paint_a = a; x.paint_b = b; x.paint_c = c; x.paint_d = d;
    x.paint_tx = tx; x.paint_ty = ty;
    return x;
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 11))
      0: return $urandom();
      1: return 32'd0;
      2, 3, 4, 5: return $urandom_range(32'h4000, 32'h0100_0000);
      6, 7, 8: return $urandom_range(1, 32'h7fff_ffff);
      9: return $urandom_range(1, 16);
      default: return $urandom_range(32'h8000, 32'h4_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return 32'(int'($urandom_range(0, 32'h6_0000)) - 32'h3_0000);
      3: return 32'd0;
      4: return 32'h0001_0000;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic ifpm_pkg::ifpm_in_t rand_item();
    ifpm_pkg::ifpm_in_t x;
    x = mk_item($urandom_range(0, 3), rand_size(), rand_size(), rand_size(), rand_size(),
                rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    case ($urandom_range(0, 7))
      0: begin
        x.paint_a = 32'h0001_0000; x.paint_b = '0; x.paint_c = '0;
        x.paint_d = 32'h0001_0000; x.paint_tx = '0; x.paint_ty = '0;
      end
      1: begin
        x.paint_a = '0; x.paint_b = '0;
      end
      default: ;
    endcase
    return x;
  endfunction

  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    send_pattern(mk_item(ifpm_pkg::MODE_FILL, one, 2*one, 3*one, 3*one,
                         one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FILL, 2*one, one, 3*one, 3*one,
                         one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FIT, one, 2*one, 3*one, 3*one,
                         one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FIT, 2*one, one, 3*one, 3*one,
                         one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FIT, one, one, one, one, 0, 0, 0, 0, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_STRETCH, 2*one, 4*one, 3*one, one,
                         one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_STRETCH, 2*one, 4*one, 3*one, one,
                         2*one, 5, 7, one, 99, -3), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_STRETCH, one, one, one, one, 0, 0, 0, 0, 5, 5), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_STRETCH, one, one, one, one, 1, 0, 0, 1, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_STRETCH, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff,
                         one, 1, 0, one, 32'h8000_0000, 32'h7fff_ffff), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_TILE, 3*one, 5*one, one, one,
                         one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FILL, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff,
                         0, 0, 0, 0, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FIT, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1,
                         0, 0, 0, 0, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FILL, 0, one, one, one, 32'h8000_0000, 32'h7fff_ffff,
                         32'hffff_ffff, 1, 32'hdead_beef, 32'h1234_5678), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_STRETCH, one, 32'h8000_0000, one, one,
                         one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_TILE, one, one, 32'hffff_ffff, one,
                         3, 4, 5, 6, 7, 8), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_FIT, one, one, one, 0, one, 0, 0, one, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_STRETCH, one, one, one, one,
                         32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff), 1);
    wait_drained();
  endtask

  task automatic test_tile_regs();
    write_reg(ifpm_pkg::CFG_SCALE_FACTOR, 31'h7fff_ffff);
    write_reg(ifpm_pkg::CFG_ORIG_WIDTH, 31'h7fff_ffff);
    write_reg(ifpm_pkg::CFG_ORIG_HEIGHT, 31'd1);
    send_pattern(mk_item(ifpm_pkg::MODE_TILE, 1, 32'h7fff_ffff, 1, 1,
                         0, 0, 0, 0, 0, 0), 1);
    send_pattern(mk_item(ifpm_pkg::MODE_TILE, 32'h7fff_ffff, 1, 1, 1,
                         0, 0, 0, 0, 0, 0), 1);
    wait_drained();
    write_reg(ifpm_pkg::CFG_SCALE_FACTOR, 31'd0);
    write_reg(ifpm_pkg::CFG_ORIG_WIDTH, 31'd0);
    send_pattern(mk_item(ifpm_pkg::MODE_TILE, 5, 7, 1, 1, 0, 0, 0, 0, 0, 0), 1);
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count) send_pattern(rand_item(), 1);
    wait_drained();
  endtask

  // hold the sender until the back end has emptied, then burst
  task automatic test_backpressure();
    repeat (12) send_pattern(rand_item(), 0);
    wait_drained();
    repeat (12) send_pattern(rand_item(), 0);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    items_sent = 0;
    matrices_seen = 0;
    tile_scale = ifpm_pkg::SCALE_RESET;
    tile_orig_w = '0;
    tile_orig_h = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(300);
    test_tile_regs();
    write_reg(ifpm_pkg::CFG_SCALE_FACTOR, $urandom_range(0, 32'h7fff_ffff));
    write_reg(ifpm_pkg::CFG_ORIG_WIDTH, $urandom_range(1, 32'h7fff_ffff));
    write_reg(ifpm_pkg::CFG_ORIG_HEIGHT, $urandom_range(1, 32'h7fff_ffff));
    test_random(300);
    test_backpressure();
    write_reg(ifpm_pkg::CFG_SCALE_FACTOR, $urandom_range(32'h4000, 32'h4_0000));
    write_reg(ifpm_pkg::CFG_ORIG_WIDTH, $urandom_range(32'h8000, 32'h0100_0000));
    write_reg(ifpm_pkg::CFG_ORIG_HEIGHT, $urandom_range(32'h8000, 32'h0100_0000));
    test_random(330);
    write_reg(ifpm_pkg::CFG_SCALE_FACTOR, $urandom());
    write_reg(ifpm_pkg::CFG_ORIG_WIDTH, 31'd0);
    write_reg(ifpm_pkg::CFG_ORIG_HEIGHT, $urandom());
    test_random(330);

    $display("tb: %0d patterns across fill, fit, stretch and tile, %0d matrices checked",
             items_sent, matrices_seen);
    $display("tb: tile registers swept through reset, zero, maximum and random values");
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ifpm_pkg.sv
hdl/ifpm_queue.sv
hdl/ifpm_front.sv
hdl/ifpm_div.sv
hdl/ifpm_back.sv
hdl/image_fit_pattern_matrix.sv
hdl/ifpm_checker.sv
tb/tb.sv
